>>> rtl/text_mode_cell_pixel_generator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character-cell pixel generator
// Shared property forms; clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CELL_PIXEL_GENERATOR_CORE_DEFINES_SVH
`define TEXT_MODE_CELL_PIXEL_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication
`define TMPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TMPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tmpg_pkg.sv
// ----------------------------------------------------------------------------
// tmpg_pkg
// Types, constants and the palette for the character-cell pixel generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmpg_pkg;

  localparam int DEF_BORDER_WIDTH = 8;
  localparam int DEF_MAX_COLUMNS  = 32;

  localparam int COORD_W = 9;
  localparam int RGB_W   = 24;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 3;

  // Geometry fallbacks
  localparam logic [6:0] DEFAULT_COLUMNS = 7'd22;
  localparam logic [5:0] DEFAULT_ROWS    = 6'd23;
  localparam logic [5:0] ROW_LIMIT       = 6'd32;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COLUMNS    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROWS       = 3'd1;
  localparam logic [IDX_W-1:0] REG_BACKGROUND = 3'd2;
  localparam logic [IDX_W-1:0] REG_BORDER     = 3'd3;
  localparam logic [IDX_W-1:0] REG_AUXILIARY  = 3'd4;
  localparam logic [IDX_W-1:0] REG_NORMAL     = 3'd5;

  // Multicolour pair codes
  localparam logic [1:0] PAIR_BACKGROUND = 2'd0;
  localparam logic [1:0] PAIR_BORDER     = 2'd1;
  localparam logic [1:0] PAIR_FOREGROUND = 2'd2;
  localparam logic [1:0] PAIR_AUXILIARY  = 2'd3;

  // Queue between front and back
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [6:0] columns_setting;
    logic [5:0] rows_setting;
    logic [3:0] background_colour;
    logic [2:0] border_colour;
    logic [3:0] auxiliary_colour;
    logic       normal_video;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    columns_setting:   7'd22,
    rows_setting:      6'd23,
    background_colour: 4'd1,
    border_colour:     3'd3,
    auxiliary_colour:  4'd0,
    normal_video:      1'b1
  };

  // One glyph row as handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y;
    logic               frame_end;
    logic [7:0]         glyph_bits;
    logic [3:0]         cell_colour;
  } desc_t;

  function automatic logic [RGB_W-1:0] palette_rgb(input logic [3:0] idx);
    logic [RGB_W-1:0] rgb;
    unique case (idx)
      4'd0:  rgb = 24'h000000;
      4'd1:  rgb = 24'hFFFFFF;
      4'd2:  rgb = 24'h772D26;
      4'd3:  rgb = 24'h85D4DC;
      4'd4:  rgb = 24'hA85FB4;
      4'd5:  rgb = 24'h559E4A;
      4'd6:  rgb = 24'h42348B;
      4'd7:  rgb = 24'hBDCC71;
      4'd8:  rgb = 24'hA8734A;
      4'd9:  rgb = 24'hE9B287;
      4'd10: rgb = 24'hB66862;
      4'd11: rgb = 24'hC5FFFF;
      4'd12: rgb = 24'hE99DF5;
      4'd13: rgb = 24'h92DF87;
      4'd14: rgb = 24'h7E70CA;
      4'd15: rgb = 24'hFFFFB0;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tmpg_front.sv
// ----------------------------------------------------------------------------
// tmpg_front
// Accepts glyph rows, tracks the cell position and builds a descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmpg_front
  import tmpg_pkg::*;
#(
  parameter int BORDER_WIDTH = DEF_BORDER_WIDTH,
  parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  accept,
  input  wire logic [7:0] glyph_bits,
  input  wire logic [3:0] cell_colour,
  output desc_t      desc
);

  localparam int SumW = $clog2(BORDER_WIDTH + 256) + 1;

  logic [2:0] glyph_row_count;
  logic [4:0] cell_column_count;
  logic [4:0] cell_row_count;

  logic [6:0]      cols;
  logic [5:0]      rows;
  logic            last_row_of_cell;
  logic            last_col;
  logic            last_line;
  logic [SumW-1:0] x_sum;
  logic [SumW-1:0] y_sum;

  always_comb begin
    cols = (cfg.columns_setting == 7'd0 ||
            cfg.columns_setting > 7'(MAX_COLUMNS)) ? DEFAULT_COLUMNS
                                                    : cfg.columns_setting;
    rows = (cfg.rows_setting == 6'd0 || cfg.rows_setting > ROW_LIMIT) ? DEFAULT_ROWS
                                                                      : cfg.rows_setting;
    last_row_of_cell = (glyph_row_count == 3'd7);
    last_col  = ({2'b00, cell_column_count} + 7'd1) >= cols;
    last_line = ({1'b0, cell_row_count} + 6'd1) >= rows;

    x_sum = SumW'(BORDER_WIDTH) + SumW'({cell_column_count, 3'b000});
    y_sum = SumW'(BORDER_WIDTH) + SumW'({cell_row_count, glyph_row_count});

    desc.x0          = x_sum[COORD_W-1:0];
    desc.y           = y_sum[COORD_W-1:0];
    desc.frame_end   = last_row_of_cell && last_col && last_line;
    desc.glyph_bits  = glyph_bits;
    desc.cell_colour = cell_colour;
  end

  // Advance the cell raster on every accepted row
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_row_count   <= '0;
      cell_column_count <= '0;
      cell_row_count    <= '0;
    end else if (accept) begin
      if (!last_row_of_cell) begin
        glyph_row_count <= glyph_row_count + 3'd1;
      end else begin
        glyph_row_count <= '0;
        if (!last_col) begin
          cell_column_count <= cell_column_count + 5'd1;
        end else begin
          cell_column_count <= '0;
          cell_row_count    <= last_line ? 5'd0 : cell_row_count + 5'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tmpg_queue.sv
// ----------------------------------------------------------------------------
// tmpg_queue
// Short descriptor queue that decouples the front from the pixel back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmpg_queue
  import tmpg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_desc,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output desc_t      head
);

  localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  desc_t           entries [QDEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == (PtrW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      priority if (do_push && !do_pop) begin
        count <= count + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PtrW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tmpg_back.sv
// ----------------------------------------------------------------------------
// tmpg_back
// Expands one descriptor into eight pixels, one per clock unless m_tready stalls, with palette RGB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmpg_back
  import tmpg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  head_valid,
  input  wire desc_t head,
  output logic       pop,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  output logic [COORD_W-1:0] pixel_x,
  output logic [COORD_W-1:0] pixel_y,
  output logic [RGB_W-1:0]   pixel_rgb,
  output logic       last_of_row,
  output logic       frame_done
);

  logic [2:0] pix;
  logic       load;
  logic       hi_on;
  logic [1:0] pair;
  logic [3:0] idx;

  assign load = head_valid && (!m_tvalid || m_tready);
  assign pop  = load && (pix == 3'd7);

  always_comb begin
    // Leftmost pixel is the MSB: bit 7 - pix is bit ~pix
    hi_on = head.glyph_bits[~pix] ^ ~cfg.normal_video;
    pair  = {head.glyph_bits[{~pix[2:1], 1'b1}], head.glyph_bits[{~pix[2:1], 1'b0}]};
    if (head.cell_colour[3]) begin
      unique case (pair)
        PAIR_BACKGROUND: idx = cfg.background_colour;
        PAIR_BORDER:     idx = {1'b0, cfg.border_colour};
        PAIR_FOREGROUND: idx = {1'b0, head.cell_colour[2:0]};
        PAIR_AUXILIARY:  idx = cfg.auxiliary_colour;
        default:         idx = cfg.background_colour;
      endcase
    end else begin
      idx = hi_on ? {1'b0, head.cell_colour[2:0]} : cfg.background_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pix      <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      pix      <= pix + 3'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x     <= head.x0 + COORD_W'(pix);
      pixel_y     <= head.y;
      pixel_rgb   <= palette_rgb(idx);
      last_of_row <= (pix == 3'd7);
      frame_done  <= (pix == 3'd7) && head.frame_end;
    end
  end

endmodule

`default_nettype wire

>>> rtl/text_mode_cell_pixel_generator_core.sv
// The first pixel of an accepted row is registered in the queue, then in the pixel output registers.
// Eight pixels per input row, one pixel per clock from the pixel stage unless m_tready stalls it.
// A two-entry row queue lets the input take the next row while pixels drain.
// Reset: raster counters and queue clear, registers take their defaults at once.
// No clearing pass; the block is ready in the cycle after reset drops.
// ----------------------------------------------------------------------------
// text_mode_cell_pixel_generator_core
// Character-cell pixel generator: glyph rows in, framebuffer pixels out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_mode_cell_pixel_generator_core_defines.svh"

module text_mode_cell_pixel_generator_core
  import tmpg_pkg::*;
#(
  parameter int BORDER_WIDTH = DEF_BORDER_WIDTH,
  parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [15:0]      s_tdata,   // glyph_bits[7:0], cell_colour[11:8], zero pad
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [47:0]           m_tdata,   // pixel_x[8:0], pixel_y[17:9], pixel_rgb[41:18]
  output logic                  m_tlast,   // last_of_row
  output logic                  m_tuser    // frame_done
);

  cfg_t  cfg;
  desc_t front_desc;
  desc_t head;
  logic  full;
  logic  head_valid;
  logic  pop;
  logic  accept;

  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [RGB_W-1:0]   pixel_rgb;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {6'b0, pixel_rgb, pixel_y, pixel_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS:    cfg.columns_setting   <= cfg_data;
        REG_ROWS:       cfg.rows_setting      <= cfg_data[5:0];
        REG_BACKGROUND: cfg.background_colour <= cfg_data[3:0];
        REG_BORDER:     cfg.border_colour     <= cfg_data[2:0];
        REG_AUXILIARY:  cfg.auxiliary_colour  <= cfg_data[3:0];
        REG_NORMAL:     cfg.normal_video      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tmpg_front #(
    .BORDER_WIDTH (BORDER_WIDTH),
    .MAX_COLUMNS  (MAX_COLUMNS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .glyph_bits  (s_tdata[7:0]),
    .cell_colour (s_tdata[11:8]),
    .desc        (front_desc)
  );

  tmpg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_desc  (front_desc),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tmpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_rgb   (pixel_rgb),
    .last_of_row (m_tlast),
    .frame_done  (m_tuser)
  );

  // Frame end only ever marks the eighth pixel of a row
  `TMPG_ASSERT_NOW(a_frame_on_last, m_tvalid && m_tuser, m_tlast, "frame_done off row end")

  // Pixels of one row follow without a gap once one is taken
  `TMPG_ASSERT_NEXT(a_row_no_gap, m_tvalid && m_tready && !m_tlast, m_tvalid,
    "gap inside a glyph row")

  // Within a row, x steps by one
  `TMPG_ASSERT_NEXT(a_x_step, m_tvalid && m_tready && !m_tlast,
    m_tdata[8:0] == 9'($past(m_tdata[8:0]) + 9'd1), "pixel_x did not advance")

endmodule

`default_nettype wire
